// ===== rtl/core/dsgc_pkg.sv =====
// Shared types, constants and helpers for the delimiter search and gap check block.
// Used by dsgc_cell, dsgc_out_buf, delimiter_search_gap_check_unit and dsgc_checker.
package dsgc_pkg;

    localparam int PATTERN_MAX_DEF = 8;
    localparam int PAT_BYTES_W     = 64;
    localparam int PAT_LEN_W       = 4;
    localparam int GAP_W           = 32;
    localparam int POS_W           = 32;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_ADDR_W      = 5;
    localparam int IN_TDATA_W      = 8;
    localparam int OUT_TDATA_W     = 40;

    typedef enum logic [1:0] {
        REG_PATTERN_BYTES  = 2'd0,
        REG_PATTERN_LENGTH = 2'd1,
        REG_MAX_GAP        = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctl_t;

    typedef struct packed {
        logic             scan_ok;
        logic             gap_exceeded;
        logic [POS_W-1:0] match_start;
        logic             matched;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

    function automatic logic [7:0] pat_byte(input logic [PAT_BYTES_W-1:0] pattern,
                                            input logic [2:0] idx);
        pat_byte = pattern[{idx, 3'b000} +: 8];
    endfunction

endpackage

// ===== rtl/core/dsgc_cell.sv =====
// One history cell: holds one past byte and compares it with its pattern byte.
// Depends on dsgc_pkg.
module dsgc_cell #(
    parameter int K = 0
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  dsgc_pkg::cell_ctl_t               ctl,
    input  logic [7:0]                        byte_in,
    input  logic [dsgc_pkg::PAT_BYTES_W-1:0]  pattern_bytes,
    input  logic [dsgc_pkg::PAT_LEN_W-1:0]    pattern_length,
    input  logic                              ok_in,
    output logic [7:0]                        byte_out,
    output logic                              ok_out
);
    import dsgc_pkg::*;

    localparam logic [PAT_LEN_W-1:0] KOFF = PAT_LEN_W'(K + 2);
    localparam logic [PAT_LEN_W:0]   KPOS = (PAT_LEN_W + 1)'(K + 1);

    logic [7:0]           hist_reg;
    logic [7:0]           hist_next;
    logic [PAT_LEN_W-1:0] sel;
    logic                 needed;

    always_comb
    begin
        hist_next = hist_reg;
        if (ctl.shift)
        begin
            hist_next = ctl.clear ? 8'd0 : byte_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= 8'd0;
        end
        else
        begin
            hist_reg <= hist_next;
        end
    end

    assign sel      = pattern_length - KOFF;
    assign needed   = KPOS < {1'b0, pattern_length};
    assign ok_out   = ok_in && (!needed || (hist_reg == pat_byte(pattern_bytes, sel[2:0])));
    assign byte_out = hist_reg;

endmodule

// ===== rtl/core/dsgc_out_buf.sv =====
// Output register with one skid entry for the result stream.
// Depends on dsgc_pkg for the result width.
module dsgc_out_buf #(
    parameter int WIDTH = dsgc_pkg::RESULT_W + 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             push_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    import dsgc_pkg::*;

    logic             main_valid_reg;
    logic             main_valid_next;
    logic [WIDTH-1:0] main_data_reg;
    logic [WIDTH-1:0] main_data_next;
    logic             skid_valid_reg;
    logic             skid_valid_next;
    logic [WIDTH-1:0] skid_data_reg;
    logic [WIDTH-1:0] skid_data_next;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_data_next  = main_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!main_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                main_valid_next = 1'b1;
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = push;
                main_data_next  = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign push_ready = !skid_valid_reg;
    assign out_valid  = main_valid_reg;
    assign out_data   = main_data_reg;

endmodule

// ===== rtl/core/delimiter_search_gap_check_unit.sv =====
// Top level of the delimiter search and gap check block.
// Depends on dsgc_pkg, dsgc_cell and dsgc_out_buf.
//
// Usage:
//   Bytes enter on the s_ stream, one per transfer; s_tlast marks the final
//   byte of a stream. A row of PATTERN_MAX-1 cells shifts the byte history
//   and compares every stored byte with its pattern byte in parallel, so a
//   byte is taken in every cycle while s_tready is high.
//   A transfer on m_ comes out for each byte on which a pattern occurrence
//   ends and for each last byte; m_tlast marks the end-of-scan result,
//   which carries the pass flag. Other bytes give no transfer.
//   Each result is registered before m_tvalid shows it. The block takes one
//   byte per cycle while s_tready is high, since the cell compare is combinational.
//   When the receiver stalls, one result waits in the output register and a
//   second in the skid entry; s_tready drops only when both are held.
//   Reset clears the configuration registers, the history cells, the
//   position and match state and both output entries. The scan state also
//   returns to its reset value after each last byte.
//   Registers sit on the APB port at byte addresses 0, 8 and 16:
//   pattern_bytes, pattern_length and max_gap. Write them only while idle.
module delimiter_search_gap_check_unit #(
    parameter int PATTERN_MAX = dsgc_pkg::PATTERN_MAX_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dsgc_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [dsgc_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [dsgc_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [dsgc_pkg::IN_TDATA_W-1:0]     s_tdata,  // [7:0] data_byte
    input  logic                                s_tlast,  // last_byte
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] matched, [32:1] match_start, [33] gap_exceeded, [34] scan_ok, [39:35] zero
    output logic [dsgc_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                                m_tlast   // scan_done
);
    import dsgc_pkg::*;

    localparam int CELLS     = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;
    localparam int PAT_LIMIT = (PATTERN_MAX < 8) ? PATTERN_MAX : 8;
    localparam logic [PAT_LEN_W-1:0] LEN_LIMIT = PAT_LEN_W'(PAT_LIMIT);

    logic [PAT_BYTES_W-1:0] pattern_bytes_reg;
    logic [PAT_LEN_W-1:0]   pattern_length_reg;
    logic [GAP_W-1:0]       max_gap_reg;
    cfg_reg_t               reg_sel;
    logic                   cfg_write;

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [POS_W-1:0] prev_start_reg;
    logic [POS_W-1:0] prev_start_next;
    logic             any_seen_reg;
    logic             any_seen_next;
    logic             gap_failed_reg;
    logic             gap_failed_next;
    logic             sat_reg;
    logic             sat_next;

    logic             accept;
    logic             last;
    logic             sat_now;
    logic             len_ok;
    logic             pos_ok;
    logic             cur_ok;
    logic             hit;
    logic             gap;
    logic             scan_ok;
    logic [POS_W-1:0] len_m1;
    logic [POS_W-1:0] start;
    logic [POS_W-1:0] start_delta;
    logic [PAT_LEN_W-1:0] cur_sel;
    cell_ctl_t        ctl;
    result_t          res;
    logic             push;
    logic             push_ready;
    logic [RESULT_W:0] out_word;

    logic [7:0] byte_chain [0:CELLS];
    logic       ok_chain   [0:CELLS];

    // configuration port
    assign pready    = 1'b1;
    assign reg_sel   = cfg_reg_t'(paddr[4:3]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bytes_reg  <= '0;
            pattern_length_reg <= '0;
            max_gap_reg        <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                REG_PATTERN_BYTES:  pattern_bytes_reg  <= pwdata;
                REG_PATTERN_LENGTH: pattern_length_reg <= pwdata[PAT_LEN_W-1:0];
                REG_MAX_GAP:        max_gap_reg        <= pwdata[GAP_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_PATTERN_BYTES:  prdata = pattern_bytes_reg;
            REG_PATTERN_LENGTH: prdata = {{(CFG_DATA_W-PAT_LEN_W){1'b0}}, pattern_length_reg};
            REG_MAX_GAP:        prdata = {{(CFG_DATA_W-GAP_W){1'b0}}, max_gap_reg};
            default:            prdata = '0;
        endcase
    end

    // history cells
    assign accept     = s_tvalid && s_tready;
    assign last       = s_tlast;
    assign ctl.shift  = accept;
    assign ctl.clear  = last;
    assign byte_chain[0] = s_tdata[7:0];
    assign ok_chain[0]   = 1'b1;

    for (genvar k = 0; k < CELLS; k++)
    begin : g_cell
        dsgc_cell #(
            .K(k)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .ctl            (ctl),
            .byte_in        (byte_chain[k]),
            .pattern_bytes  (pattern_bytes_reg),
            .pattern_length (pattern_length_reg),
            .ok_in          (ok_chain[k]),
            .byte_out       (byte_chain[k+1]),
            .ok_out         (ok_chain[k+1])
        );
    end

    // match and gap check
    assign sat_now = sat_reg || (pos_reg == '1);
    assign len_ok  = (pattern_length_reg != '0) && (pattern_length_reg <= LEN_LIMIT);
    assign len_m1  = {{(POS_W-PAT_LEN_W){1'b0}}, pattern_length_reg} - POS_W'(1);
    assign pos_ok  = pos_reg >= len_m1;
    assign cur_sel = pattern_length_reg - PAT_LEN_W'(1);
    assign cur_ok  = pat_byte(pattern_bytes_reg, cur_sel[2:0]) == s_tdata[7:0];
    assign hit     = !sat_now && len_ok && pos_ok && cur_ok && ok_chain[CELLS];
    assign start   = pos_reg - len_m1;
    assign start_delta = start - prev_start_reg;
    assign gap     = hit && any_seen_reg && (start_delta > max_gap_reg);
    assign scan_ok = last && (any_seen_reg || hit) && !(gap_failed_reg || gap) && !sat_now
                     && (pattern_length_reg != '0) && (max_gap_reg != '0);

    always_comb
    begin
        pos_next        = pos_reg;
        prev_start_next = prev_start_reg;
        any_seen_next   = any_seen_reg;
        gap_failed_next = gap_failed_reg;
        sat_next        = sat_reg;
        if (accept)
        begin
            if (last)
            begin
                pos_next        = '0;
                prev_start_next = '0;
                any_seen_next   = 1'b0;
                gap_failed_next = 1'b0;
                sat_next        = 1'b0;
            end
            else
            begin
                sat_next = sat_now;
                if (pos_reg != '1)
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
                if (hit)
                begin
                    prev_start_next = start;
                    any_seen_next   = 1'b1;
                    gap_failed_next = gap_failed_reg || gap;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            prev_start_reg <= '0;
            any_seen_reg   <= 1'b0;
            gap_failed_reg <= 1'b0;
            sat_reg        <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            prev_start_reg <= prev_start_next;
            any_seen_reg   <= any_seen_next;
            gap_failed_reg <= gap_failed_next;
            sat_reg        <= sat_next;
        end
    end

    // result stream
    assign res.matched      = hit;
    assign res.match_start  = hit ? start : '0;
    assign res.gap_exceeded = gap;
    assign res.scan_ok      = scan_ok;
    assign push             = accept && (hit || last);
    assign s_tready         = push_ready;

    dsgc_out_buf #(
        .WIDTH(RESULT_W + 1)
    ) u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  ({last, res}),
        .push_ready (push_ready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_word)
    );

    assign m_tlast = out_word[RESULT_W];
    assign m_tdata = {{(OUT_TDATA_W-RESULT_W){1'b0}}, out_word[RESULT_W-1:0]};

endmodule

// ===== rtl/core/dsgc_checker.sv =====
// Port-level checks on the result stream of delimiter_search_gap_check_unit.
// Depends on dsgc_pkg; bound to the top level below.
module dsgc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [dsgc_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                             m_tlast
);
    import dsgc_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_nomatch_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tlast)
        else $error("result without match outside scan end");

    a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> (m_tdata[33:1] == '0))
        else $error("match fields set without match");

    a_ok_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !m_tdata[34] && (m_tdata[OUT_TDATA_W-1:35] == '0))
        else $error("scan_ok set before scan end");

endmodule

bind delimiter_search_gap_check_unit dsgc_checker u_dsgc_checker (.*);

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for delimiter_search_gap_check_unit: a directed table, then random
// byte streams under changing stalls, every output transfer checked against the table or a local scan model.
// Depends on dsgc_pkg and the block's RTL.
module tb_top;
    import dsgc_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 5;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_ITEMS  = 500;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 80;
    localparam int MAX_REPORTS   = 10;
    localparam int PAT_LIMIT     = 8;
    localparam int HIST_DEPTH    = PATTERN_MAX_DEF - 1;

    typedef struct packed {
        logic             matched;
        logic [POS_W-1:0] match_start;
        logic             gap_exceeded;
        logic             scan_done;
        logic             scan_ok;
    } scan_result_t;

    typedef enum logic {
        ROW_CFG,
        ROW_BYTE
    } row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [PAT_BYTES_W-1:0] pattern;
        logic [PAT_LEN_W-1:0]   length;
        logic [GAP_W-1:0]       max_gap;
        logic [7:0]             data;
        logic                   last;
        logic                   typed;
        scan_result_t           want;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n    = 1'b0;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0]  paddr    = '0;
    logic [CFG_DATA_W-1:0]  pwdata   = '0;
    logic [CFG_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;   // [7:0] data_byte
    logic                   s_tlast  = 1'b0; // last_byte
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;         // [0] matched, [32:1] match_start,
                                             // [33] gap_exceeded, [34] scan_ok
    logic                   m_tlast;         // scan_done

    delimiter_search_gap_check_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    logic [PAT_BYTES_W-1:0] cfg_pattern;
    logic [PAT_LEN_W-1:0]   cfg_length;
    logic [GAP_W-1:0]       cfg_max_gap;

    logic [7:0]             history [HIST_DEPTH];
    logic [POS_W-1:0]       position;
    logic [POS_W-1:0]       prev_start;
    logic                   seen_match;
    logic                   gap_failed;
    logic                   pos_saturated;

    scan_result_t           expected_results[$];
    stim_row_t              directed_rows[$];
    int                     mismatch_count = 0;
    int                     cycle_count    = 0;
    int                     send_idle_pct  = 0;
    int                     recv_idle_pct  = 0;
    int                     hold_requests  = 0;
    int                     hold_taken     = 0;
    int                     hold_left      = 0;
    int                     random_sent    = 0;

    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    always @(posedge clk) cycle_count <= cycle_count + 1;

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge clk);
        $display("FAIL");
        $finish;
    end

    function automatic void clear_scan_state();
        foreach (history[k]) history[k] = 8'h00;
        position      = '0;
        prev_start    = '0;
        seen_match    = 1'b0;
        gap_failed    = 1'b0;
        pos_saturated = 1'b0;
    endfunction

    function automatic logic [7:0] pattern_at(int idx);
        return cfg_pattern[(idx & 7) * 8 +: 8];
    endfunction

    function automatic logic occurrence_ends(logic [7:0] cur);
        int len;
        len = int'(cfg_length);
        if (len == 0 || len > PAT_LIMIT || len > PATTERN_MAX_DEF)
            return 1'b0;
        if (position < POS_W'(len - 1))
            return 1'b0;
        if (pattern_at(len - 1) != cur)
            return 1'b0;
        for (int k = 0; k + 1 < len; k++) begin
            if (k >= HIST_DEPTH)
                return 1'b0;
            if (history[k] != pattern_at(len - 2 - k))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Advance the scan by one byte; return 1 when the byte yields an output transfer.
    function automatic logic predict_scan_step(input logic [7:0] data, input logic last,
                                               output scan_result_t res);
        logic             hit;
        logic             gap;
        logic [POS_W-1:0] start;
        hit   = 1'b0;
        gap   = 1'b0;
        start = '0;
        if (position == '1)
            pos_saturated = 1'b1;
        if (!pos_saturated && occurrence_ends(data)) begin
            hit   = 1'b1;
            start = position - (POS_W'(cfg_length) - 1);
            if (seen_match && (start - prev_start) > cfg_max_gap)
                gap = 1'b1;
            if (gap)
                gap_failed = 1'b1;
            seen_match = 1'b1;
            prev_start = start;
        end
        for (int k = HIST_DEPTH - 1; k > 0; k--)
            history[k] = history[k - 1];
        history[0] = data;
        if (position != '1)
            position = position + 1;
        res.matched      = hit;
        res.match_start  = hit ? start : '0;
        res.gap_exceeded = gap;
        res.scan_done    = last;
        res.scan_ok      = last && seen_match && !gap_failed && !pos_saturated
                           && cfg_length != 0 && cfg_max_gap != 0;
        if (last)
            clear_scan_state();
        return hit || last;
    endfunction

    function automatic scan_result_t scan_result(logic m, logic [POS_W-1:0] start, logic gap,
                                                 logic done, logic ok);
        scan_result_t r;
        r.matched      = m;
        r.match_start  = start;
        r.gap_exceeded = gap;
        r.scan_done    = done;
        r.scan_ok      = ok;
        return r;
    endfunction

    function automatic void report_mismatch(string what, scan_result_t want, scan_result_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s expected m=%0d start=%0d gap=%0d done=%0d ok=%0d,",
                     $realtime, what, want.matched, want.match_start, want.gap_exceeded,
                     want.scan_done, want.scan_ok,
                     " got m=%0d start=%0d gap=%0d done=%0d ok=%0d tdata=%h",
                     got.matched, got.match_start, got.gap_exceeded, got.scan_done,
                     got.scan_ok, m_tdata);
    endfunction

    function automatic void add_cfg(logic [63:0] pattern, logic [3:0] length, logic [31:0] gap);
        stim_row_t row;
        row         = '{kind: ROW_CFG, default: '0};
        row.pattern = pattern;
        row.length  = length;
        row.max_gap = gap;
        directed_rows = {directed_rows, row};
    endfunction

    function automatic void add_byte(logic [7:0] data, logic last, logic typed,
                                     scan_result_t want);
        stim_row_t row;
        row       = '{kind: ROW_BYTE, default: '0};
        row.data  = data;
        row.last  = last;
        row.typed = typed;
        row.want  = want;
        directed_rows = {directed_rows, row};
    endfunction

    // Sample at the falling edge; the transfer itself happens at the next rising edge.
    always @(negedge clk) begin : out_check
        scan_result_t got;
        scan_result_t want;
        if (rst_n && m_tvalid && m_tready) begin
            got.matched      = m_tdata[0];
            got.match_start  = m_tdata[32:1];
            got.gap_exceeded = m_tdata[33];
            got.scan_ok      = m_tdata[34];
            got.scan_done    = m_tlast;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected transfer (none pending)", '0, got);
            end
            else begin
                want = expected_results.pop_front();
                if (got !== want || m_tdata[OUT_TDATA_W-1:35] !== '0)
                    report_mismatch("result mismatch", want, got);
            end
        end
    end

    always @(posedge clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (hold_taken != hold_requests) begin
            hold_taken <= hold_requests;
            hold_left  <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end
        else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_byte(input logic [7:0] data, input logic last, input logic typed,
                             input scan_result_t want);
        scan_result_t predicted;
        logic         produces;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= last;
        @(negedge clk);
        while (!s_tready) @(negedge clk);
        @(posedge clk);
        produces = predict_scan_step(data, last, predicted);
        if (typed)
            expected_results = {expected_results, want};
        else if (produces)
            expected_results = {expected_results, predicted};
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        while (!pready) @(negedge clk);
        @(posedge clk);
        case (sel)
            REG_PATTERN_BYTES:  cfg_pattern = value;
            REG_PATTERN_LENGTH: cfg_length  = value[PAT_LEN_W-1:0];
            REG_MAX_GAP:        cfg_max_gap = value[GAP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_config(input logic [63:0] pattern, input logic [3:0] length,
                                input logic [31:0] gap);
        wait_idle();
        write_reg(REG_PATTERN_BYTES, pattern);
        write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(length));
        write_reg(REG_MAX_GAP, CFG_DATA_W'(gap));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Mostly whole pattern occurrences, mixed with cut-off prefixes and noise bytes.
    task automatic send_stream(input int n);
        logic [7:0] bytes[$];
        int         plen;
        int         cut;
        plen = (cfg_length >= 1 && cfg_length <= PAT_LIMIT) ? int'(cfg_length) : 3;
        while (bytes.size() < n) begin
            case ($urandom_range(9))
                0, 1, 2, 3: for (int i = 0; i < plen; i++) bytes = {bytes, pattern_at(i)};
                4, 5: bytes = {bytes, pattern_at($urandom_range(plen - 1))};
                6: begin
                    cut = $urandom_range(plen - 1);
                    for (int i = 0; i < cut; i++) bytes = {bytes, pattern_at(i)};
                    bytes = {bytes, 8'($urandom)};
                end
                default: bytes = {bytes, 8'($urandom)};
            endcase
        end
        while (bytes.size() > n) void'(bytes.pop_back());
        foreach (bytes[i]) send_byte(bytes[i], i == n - 1, 1'b0, '0);
        random_sent += n;
    endtask

    initial begin : stimulus
        logic [63:0] pat;
        logic [3:0]  len;
        logic [31:0] gap;
        logic        pressure_done;
        int          streams;

        cfg_pattern   = '0;
        cfg_length    = '0;
        cfg_max_gap   = '0;
        pressure_done = 1'b0;
        clear_scan_state();

        // after reset: matching is off, so the scan fails
        add_byte(8'h00, 1'b1, 1'b1, scan_result(1'b0, 32'd0, 1'b0, 1'b1, 1'b0));
        // one-byte pattern, all-ones register, gap limit 1
        add_cfg(64'hFFFF_FFFF_FFFF_FFFF, 4'd1, 32'd1);
        add_byte(8'hFF, 1'b0, 1'b1, scan_result(1'b1, 32'd0, 1'b0, 1'b0, 1'b0));
        add_byte(8'hFF, 1'b0, 1'b1, scan_result(1'b1, 32'd1, 1'b0, 1'b0, 1'b0));
        add_byte(8'h00, 1'b0, 1'b0, '0);
        add_byte(8'hFF, 1'b1, 1'b1, scan_result(1'b1, 32'd3, 1'b1, 1'b1, 1'b0));
        // full eight-byte pattern, widest gap limit
        add_cfg(64'h0807_0605_0403_0201, 4'd8, 32'hFFFF_FFFF);
        for (int i = 1; i <= 8; i++) add_byte(8'(i), i == 8, 1'b0, '0);
        // stream shorter than the pattern
        for (int i = 1; i <= 3; i++) add_byte(8'(i), i == 3, 1'b0, '0);
        // overlapping occurrences with zero gap limit
        add_cfg(64'h0000_0000_0000_AAAA, 4'd2, 32'd0);
        for (int i = 0; i < 3; i++) add_byte(8'hAA, i == 2, 1'b0, '0);
        // length beyond the pattern register never matches
        add_cfg(64'h0000_0000_0000_AAAA, 4'd15, 32'd5);
        add_byte(8'hAA, 1'b0, 1'b0, '0);
        add_byte(8'hAA, 1'b1, 1'b1, scan_result(1'b0, 32'd0, 1'b0, 1'b1, 1'b0));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG)
                write_config(directed_rows[i].pattern, directed_rows[i].length,
                             directed_rows[i].max_gap);
            else
                send_byte(directed_rows[i].data, directed_rows[i].last,
                          directed_rows[i].typed, directed_rows[i].want);
        end

        while (random_sent < RANDOM_ITEMS) begin
            if (random_sent < RANDOM_ITEMS / 3) begin
                send_idle_pct = 27;
                recv_idle_pct = 86;
            end
            else if (random_sent < 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 86;
                recv_idle_pct = 27;
            end
            else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            if (send_idle_pct == 0 && !pressure_done) begin
                // every byte matches while the receiver holds off, so the block backs up
                write_config(64'h3C, 4'd1, 32'hFFFF_FFFF);
                hold_requests++;
                for (int i = 0; i < 40; i++) send_byte(8'h3C, i == 39, 1'b0, '0);
                random_sent  += 40;
                pressure_done = 1'b1;
            end

            case ($urandom_range(19))
                0:          len = 4'd0;
                1, 2:       len = 4'($urandom_range(9, 15));
                3, 4, 5:    len = 4'($urandom_range(5, 8));
                default:    len = 4'($urandom_range(1, 4));
            endcase
            for (int b = 0; b < 8; b++)
                pat[b * 8 +: 8] = ($urandom_range(3) == 0) ? 8'($urandom)
                                  : ($urandom_range(1) ? 8'hA5 : 8'h5A);
            case ($urandom_range(9))
                0:          gap = 32'd0;
                1:          gap = 32'hFFFF_FFFF;
                2:          gap = $urandom;
                3, 4, 5:    gap = 32'($urandom_range(1, 4));
                default:    gap = 32'($urandom_range(5, 30));
            endcase
            write_config(pat, len, gap);

            streams = $urandom_range(1, 4);
            for (int s = 0; s < streams; s++)
                send_stream(($urandom_range(9) == 0) ? 60 : $urandom_range(1, 24));
        end

        wait_idle();
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/dsgc_pkg.sv
rtl/core/dsgc_cell.sv
rtl/core/dsgc_out_buf.sv
rtl/core/delimiter_search_gap_check_unit.sv
rtl/core/dsgc_checker.sv
bench/tb_top.sv
